[src/paged_flash_command_controller_defines.svh]
// ----------------------------------------------------------------------------
// Paged flash command controller: assertion macros
// Shared helpers for the concurrent checks in the controller.
// ----------------------------------------------------------------------------
`ifndef PAGED_FLASH_COMMAND_CONTROLLER_DEFINES_SVH
`define PAGED_FLASH_COMMAND_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define PFCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during rst.
`define PFCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pfcc_pkg.sv]
// ----------------------------------------------------------------------------
// Paged flash command controller package
// Codes, constants and the control and status bundles shared by the modules.
// ----------------------------------------------------------------------------
package pfcc_pkg;

  // Both sizes are powers of two, so wrapping is a matter of keeping low bits.
  localparam int FLASH_BYTES_DEF = 131072;
  localparam int PAGE_BYTES_DEF  = 128;

  localparam int KIND_W     = 2;
  localparam int CMD_W      = 32;
  localparam int OPCODE_W   = 8;
  localparam int PAGE_NUM_W = 16;
  localparam int BIDX_W     = 7;
  localparam int BYTE_W     = 8;
  localparam int HALF_W     = 16;
  localparam int RIDX_W     = 17;
  localparam int STATUS_W   = 64;
  localparam int ERR_W      = 2;
  localparam int MODE_W     = 3;

  localparam logic [KIND_W-1:0] KIND_CMD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [OPCODE_W-1:0] OP_SET_PAGE   = 8'h4b;
  localparam logic [OPCODE_W-1:0] OP_ERASE      = 8'h78;
  localparam logic [OPCODE_W-1:0] OP_SET_PAGE_W = 8'ha5;
  localparam logic [OPCODE_W-1:0] OP_WRITE      = 8'hb4;
  localparam logic [OPCODE_W-1:0] OP_EXECUTE    = 8'hd2;
  localparam logic [OPCODE_W-1:0] OP_STATUS     = 8'he1;
  localparam logic [OPCODE_W-1:0] OP_READ       = 8'hf0;

  localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STATUS = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [ERR_W-1:0] ERR_MODE    = 2'd2;

  localparam logic [1:0] SSEL_ERASE  = 2'd0;
  localparam logic [1:0] SSEL_WRITE  = 2'd1;
  localparam logic [1:0] SSEL_STATUS = 2'd2;
  localparam logic [1:0] SSEL_READ   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_ERASE  = 64'h1111800800c20000;
  localparam logic [STATUS_W-1:0] STATUS_WRITE  = 64'h1111800400c20000;
  localparam logic [STATUS_W-1:0] STATUS_STATUS = 64'h1111800100c20000;
  localparam logic [STATUS_W-1:0] STATUS_READ   = 64'h11118004f0000000;

  localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hff;

  typedef struct packed {
    logic             ld_out;      // load the result registers now
    logic [ERR_W-1:0] err;
    logic             set_page;
    logic             set_status;
    logic [1:0]       status_sel;
    logic             buf_wr;
    logic             rd_issue;    // start a flash read
    logic             rd_load;     // move flash read data into the result
    logic             exec_start;
    logic             exec_erase;
    logic             exec_step;
    logic             clr_step;
  } pfcc_cmd_t;

  typedef struct packed {
    logic exec_done;
    logic clr_done;
  } pfcc_sts_t;

endpackage

[src/pfcc_ctrl.sv]
// ----------------------------------------------------------------------------
// Paged flash command controller: control unit
// Decodes each input word, tracks the flash mode and sequences reads,
// page executes and the erase sweep after reset.
// ----------------------------------------------------------------------------
`include "paged_flash_command_controller_defines.svh"

module pfcc_ctrl
  import pfcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [OPCODE_W-1:0] opcode,
  output logic                out_valid,
  input  logic                out_stall,
  output pfcc_cmd_t           cmd,
  input  pfcc_sts_t           sts
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  logic [1:0]        state, state_next;
  logic [MODE_W-1:0] mode, mode_next;
  logic              out_valid_next;
  logic              out_free;
  logic              acc;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) && out_free);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    mode_next  = mode;
    cmd        = '0;
    cmd.err    = ERR_OK;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          cmd.ld_out = 1'b1;
          unique case (kind)
            KIND_CMD: begin
              unique case (opcode)
                OP_SET_PAGE: begin
                  cmd.set_page = 1'b1;
                end
                OP_ERASE: begin
                  mode_next      = MODE_ERASE;
                  cmd.set_status = 1'b1;
                  cmd.status_sel = SSEL_ERASE;
                end
                OP_SET_PAGE_W: begin
                  cmd.set_page   = 1'b1;
                  cmd.set_status = 1'b1;
                  cmd.status_sel = SSEL_WRITE;
                end
                OP_WRITE: begin
                  mode_next = MODE_WRITE;
                end
                OP_EXECUTE: begin
                  mode_next = MODE_IDLE;
                  unique case (mode) inside
                    MODE_ERASE, MODE_WRITE: begin
                      cmd.exec_start = 1'b1;
                      cmd.exec_erase = (mode == MODE_ERASE);
                      state_next     = ST_EXEC;
                    end
                    MODE_READ: begin
                      cmd.err = ERR_MODE;
                    end
                    default: begin
                    end
                  endcase
                end
                OP_STATUS: begin
                  mode_next      = MODE_STATUS;
                  cmd.set_status = 1'b1;
                  cmd.status_sel = SSEL_STATUS;
                end
                OP_READ: begin
                  mode_next      = MODE_READ;
                  cmd.set_status = 1'b1;
                  cmd.status_sel = SSEL_READ;
                end
                default: begin
                  cmd.err = ERR_UNKNOWN;
                end
              endcase
            end
            KIND_LOAD: begin
              if (mode == MODE_WRITE) begin
                cmd.buf_wr = 1'b1;
              end else begin
                cmd.err = ERR_MODE;
              end
            end
            KIND_READ: begin
              if (mode == MODE_READ) begin
                // The result waits for the registered flash read data.
                cmd.ld_out   = 1'b0;
                cmd.rd_issue = 1'b1;
                state_next   = ST_READ;
              end else if (mode != MODE_STATUS) begin
                cmd.err = ERR_MODE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.rd_load = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_EXEC: begin
        cmd.exec_step = 1'b1;
        if (sts.exec_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.ld_out || cmd.rd_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      mode      <= MODE_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      mode      <= mode_next;
      out_valid <= out_valid_next;
    end
  end

  `PFCC_ASSERT_NOW(a_result_slot_free, cmd.ld_out || cmd.rd_load, out_free,
    "result loaded while the previous word is still held")
  `PFCC_ASSERT_NOW(a_read_after_accept, state == ST_READ, $past(acc),
    "read data stage entered without an accepted read")
  `PFCC_ASSERT_NOW(a_exec_leaves_idle, state == ST_EXEC, mode == MODE_IDLE,
    "page execute running while a mode is still selected")
  `PFCC_ASSERT_NEXT(a_no_return_to_clear, state != ST_CLEAR, state != ST_CLEAR,
    "erase sweep restarted outside reset")

endmodule

[src/pfcc_dp.sv]
// ----------------------------------------------------------------------------
// Paged flash command controller: datapath
// Holds the flash store, page buffer, page address, status value and the
// result registers, and runs the page and sweep address counters.
// ----------------------------------------------------------------------------
module pfcc_dp
  import pfcc_pkg::*;
#(
  parameter int FLASH_BYTES = FLASH_BYTES_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pfcc_cmd_t             cmd,
  output pfcc_sts_t             sts,
  input  logic [PAGE_NUM_W-1:0] page_num,
  input  logic [BIDX_W-1:0]     buffer_index,
  input  logic [BYTE_W-1:0]     buffer_byte,
  input  logic [HALF_W-1:0]     read_half_offset,
  input  logic [RIDX_W-1:0]     read_byte_index,
  output logic [BYTE_W-1:0]     read_byte,
  output logic [STATUS_W-1:0]   status_value,
  output logic [ERR_W-1:0]      error
);

  localparam int ADDR_W = $clog2(FLASH_BYTES);
  localparam int PW     = $clog2(PAGE_BYTES);
  localparam int PROD_W = PAGE_NUM_W + PW + ADDR_W;
  localparam int RS_W   = ADDR_W + HALF_W + 2;
  localparam int BX_W   = BIDX_W + PW;

  logic [BYTE_W-1:0] flash_mem [FLASH_BYTES];
  logic [BYTE_W-1:0] pbuf_mem  [PAGE_BYTES];

  logic [ADDR_W-1:0]   page_addr;
  logic [STATUS_W-1:0] status_reg;
  logic [STATUS_W-1:0] status_sel_val;
  logic [ADDR_W-1:0]   clr_cnt;
  logic [PW:0]         exec_cnt;
  logic                exec_erase;
  logic [BYTE_W-1:0]   flash_rdata;
  logic [BYTE_W-1:0]   pbuf_rdata;

  logic [PROD_W-1:0] page_prod;
  logic [RS_W-1:0]   rd_sum;
  logic [BX_W-1:0]   bidx_ext;
  logic [PW-1:0]     exec_idx;
  logic [ADDR_W-1:0] exec_addr;

  // Wrapping is by power-of-two sizes, so only the low bits are kept.
  assign page_prod = PROD_W'(page_num) << PW;
  assign rd_sum    = (RS_W'(read_half_offset) << 1) + RS_W'(read_byte_index);
  assign bidx_ext  = BX_W'(buffer_index);
  assign exec_idx  = exec_cnt[PW-1:0] - PW'(1);
  assign exec_addr = page_addr + ADDR_W'(exec_idx);

  assign sts.exec_done = (exec_cnt == (PW+1)'(PAGE_BYTES));
  assign sts.clr_done  = (clr_cnt == ADDR_W'(FLASH_BYTES - 1));

  always_comb begin
    case (cmd.status_sel)
      SSEL_ERASE:  status_sel_val = STATUS_ERASE;
      SSEL_WRITE:  status_sel_val = STATUS_WRITE;
      SSEL_STATUS: status_sel_val = STATUS_STATUS;
      default:     status_sel_val = STATUS_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_addr  <= '0;
      status_reg <= '0;
      clr_cnt    <= '0;
    end else begin
      if (cmd.set_page) begin
        page_addr <= page_prod[ADDR_W-1:0];
      end
      if (cmd.set_status) begin
        status_reg <= status_sel_val;
      end
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
    end
  end

  // The page copy runs one word behind the buffer read, so the count
  // goes one past the page size.
  always_ff @(posedge clk) begin
    if (cmd.exec_start) begin
      exec_cnt   <= '0;
      exec_erase <= cmd.exec_erase;
    end else if (cmd.exec_step) begin
      exec_cnt <= exec_cnt + (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.buf_wr) begin
      pbuf_mem[bidx_ext[PW-1:0]] <= buffer_byte;
    end
    pbuf_rdata <= pbuf_mem[exec_cnt[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      flash_mem[clr_cnt] <= ERASED_BYTE;
    end else if (cmd.exec_step && (exec_cnt != '0)) begin
      flash_mem[exec_addr] <= exec_erase ? ERASED_BYTE : pbuf_rdata;
    end
    if (cmd.rd_issue) begin
      flash_rdata <= flash_mem[rd_sum[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      read_byte    <= '0;
      status_value <= cmd.set_status ? status_sel_val : status_reg;
      error        <= cmd.err;
    end else if (cmd.rd_load) begin
      read_byte    <= flash_rdata;
      status_value <= status_reg;
      error        <= ERR_OK;
    end
  end

endmodule

[src/paged_flash_command_controller.sv]
// ----------------------------------------------------------------------------
// Paged flash command controller
// Paged flash store driven by command words, page buffer loads and reads.
// ----------------------------------------------------------------------------
// Commands, buffer loads and reads outside read mode: result in the cycle after accept.
// Reads in read mode: flash data is registered, then loaded into the result registers.
// Erase or write execute: result in the cycle after accept, then in_stall is high
// while the single flash write port copies the page a byte a cycle (0xFF on erase).
// After rst the store is swept to 0xFF, with in_stall high during the sweep.
// Throughput: one word per cycle while results are taken and no read or execute runs.
module paged_flash_command_controller
  import pfcc_pkg::*;
#(
  parameter int FLASH_BYTES = FLASH_BYTES_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [CMD_W-1:0]    command_word,
  input  logic [BIDX_W-1:0]   buffer_index,
  input  logic [BYTE_W-1:0]   buffer_byte,
  input  logic [HALF_W-1:0]   read_half_offset,
  input  logic [RIDX_W-1:0]   read_byte_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BYTE_W-1:0]   read_byte,
  output logic [STATUS_W-1:0] status_value,
  output logic [ERR_W-1:0]    error
);

  pfcc_cmd_t cmd;
  pfcc_sts_t sts;

  pfcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .opcode    (command_word[CMD_W-1 -: OPCODE_W]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  pfcc_dp #(
    .FLASH_BYTES (FLASH_BYTES),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .page_num         (command_word[PAGE_NUM_W-1:0]),
    .buffer_index     (buffer_index),
    .buffer_byte      (buffer_byte),
    .read_half_offset (read_half_offset),
    .read_byte_index  (read_byte_index),
    .read_byte        (read_byte),
    .status_value     (status_value),
    .error            (error)
  );

endmodule
